/* rtl/ipv4lpm_pkg.sv */
// Shared constants, types and the candidate select function for the route lookup.
`timescale 1ns / 1ps
`default_nettype none

package ipv4lpm_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 16;
   localparam int TBL_LVLS    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int TBL_PAD     = 1 << TBL_LVLS;
   localparam int IDX_W       = TBL_LVLS;

   // Field widths
   localparam int ADDR_W = 32;
   localparam int LEN_W  = 6;
   localparam int PORT_W = 2;
   localparam int SLOT_W = 4;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

   // Split of the select tree over the three pipeline stages
   localparam int LVL_S1 = TBL_LVLS / 3;
   localparam int LVL_S2 = (TBL_LVLS - LVL_S1) / 2;
   localparam int LVL_S3 = TBL_LVLS - LVL_S1 - LVL_S2;
   localparam int S1_N   = TBL_PAD >> LVL_S1;
   localparam int S2_N   = S1_N >> LVL_S2;

   // Action codes
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // One table write beat
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] dest;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] gw;
      logic [PORT_W-1:0] port;
      logic              valid;
   } wr_type;

   // One match candidate in the select tree
   typedef struct packed {
      logic              hit;
      logic [LEN_W-1:0]  len;
      logic [IDX_W-1:0]  idx;
      logic [ADDR_W-1:0] gw;
      logic [PORT_W-1:0] port;
   } cand_type;

   // Keep the lower-index candidate a unless b is a strictly longer hit
   function automatic cand_type cand_pick(cand_type a, cand_type b);
      cand_type r;
      r = a;
      if (b.hit && (!a.hit || (b.len > a.len))) begin
         r = b;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/ipv4lpm_table.sv */
// Route table storage, parallel prefix compare and first select-tree levels.
`timescale 1ns / 1ps
`default_nettype none

module ipv4lpm_table (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire ipv4lpm_pkg::wr_type                      wr,
   input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]           addr,
   output      ipv4lpm_pkg::cand_type [ipv4lpm_pkg::S1_N-1:0] cand
);
   import ipv4lpm_pkg::*;

   logic [ADDR_W-1:0] dest_ff  [TABLE_DEPTH];
   logic [ADDR_W-1:0] mask_ff  [TABLE_DEPTH];
   logic [LEN_W-1:0]  len_ff   [TABLE_DEPTH];
   logic [ADDR_W-1:0] gw_ff    [TABLE_DEPTH];
   logic [PORT_W-1:0] port_ff  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;

   logic [SLOT_W+IDX_W-1:0] slot_ext;
   logic [IDX_W-1:0]        slot;
   logic                    slot_ok;
   logic [LEN_W-1:0]        len_sat;
   logic [ADDR_W-1:0]       mask_in;

   cand_type [TBL_PAD-1:0] leaf;
   cand_type [TBL_PAD-1:0] work;

   // Decode the write slot and saturate the prefix length
   always_comb begin
      slot_ext = (SLOT_W+IDX_W)'(wr.slot);
      slot     = slot_ext[IDX_W-1:0];
      slot_ok  = (32'(wr.slot) < 32'(TABLE_DEPTH));
      len_sat  = (wr.len > MAX_LEN) ? MAX_LEN : wr.len;
      if (len_sat == '0) begin
         mask_in = '0;
      end else begin
         mask_in = {ADDR_W{1'b1}} << (MAX_LEN - len_sat);
      end
   end

   // Load the entry payload
   always_ff @(posedge clock) begin
      if (wr.en && slot_ok) begin
         dest_ff[slot] <= wr.dest;
         mask_ff[slot] <= mask_in;
         len_ff[slot]  <= len_sat;
         gw_ff[slot]   <= wr.gw;
         port_ff[slot] <= wr.port;
      end
   end

   // Valid bits clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en && slot_ok) begin
         valid_ff[slot] <= wr.valid;
      end
   end

   // Compare the address against every entry under its mask
   for (genvar g = 0; g < TBL_PAD; g++) begin : g_leaf
      if (g < TABLE_DEPTH) begin : g_real
         assign leaf[g].hit  = valid_ff[g] && (((dest_ff[g] ^ addr) & mask_ff[g]) == '0);
         assign leaf[g].len  = len_ff[g];
         assign leaf[g].idx  = IDX_W'(g);
         assign leaf[g].gw   = gw_ff[g];
         assign leaf[g].port = port_ff[g];
      end else begin : g_pad
         assign leaf[g] = '0;
      end
   end

   // Reduce the first tree levels, lower index on the left
   always_comb begin
      work = leaf;
      for (int l = 0; l < LVL_S1; l++) begin
         for (int j = 0; j < TBL_PAD / 2; j++) begin
            if (j < (TBL_PAD >> (l + 1))) begin
               work[j] = cand_pick(work[2*j], work[2*j+1]);
            end
         end
      end
      for (int k = 0; k < S1_N; k++) begin
         cand[k] = work[k];
      end
   end

endmodule

`default_nettype wire

/* rtl/ipv4_longest_prefix_match_unit.sv */
// Top level of the IPv4 longest-prefix-match route lookup pipeline.
// A lookup is registered through stages 0, 1 and 2 and the output register, then shows its result with rsp_strobe.
// Throughput: one beat per cycle; busy stays low, so a write or lookup enters every cycle.
// A write lands in the table at its accept edge and is seen by every later lookup.
// Reset (synchronous) clears all entry valid bits and the pipeline valids; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_longest_prefix_match_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output      logic                                   busy,
   input  wire logic                                   req_action,
   input  wire logic [ipv4lpm_pkg::SLOT_W-1:0]         req_entry_index,
   input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]         req_entry_dest,
   input  wire logic [ipv4lpm_pkg::LEN_W-1:0]          req_entry_prefix_len,
   input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]         req_entry_gateway,
   input  wire logic [ipv4lpm_pkg::PORT_W-1:0]         req_entry_port,
   input  wire logic                                   req_entry_valid,
   input  wire logic [ipv4lpm_pkg::ADDR_W-1:0]         req_lookup_addr,
   output      logic                                   rsp_strobe,
   output      logic                                   rsp_hit,
   output      logic [ipv4lpm_pkg::ADDR_W-1:0]         rsp_next_hop,
   output      logic [ipv4lpm_pkg::PORT_W-1:0]         rsp_out_port,
   output      logic [ipv4lpm_pkg::SLOT_W-1:0]         rsp_match_index
);
   import ipv4lpm_pkg::*;

   logic   accept;
   wr_type wr;

   logic              s0_valid_ff, s0_valid_in;
   logic [ADDR_W-1:0] s0_addr_ff;

   logic                   s1_valid_ff;
   cand_type [S1_N-1:0]    s1_cand_ff, s1_cand_in;
   logic                   s2_valid_ff;
   cand_type [S2_N-1:0]    s2_cand_ff, s2_cand_in;
   cand_type [S2_N-1:0]    s3_work;

   logic              out_valid_ff;
   logic              out_hit_ff, out_hit_in;
   logic [ADDR_W-1:0] out_gw_ff, out_gw_in;
   logic [PORT_W-1:0] out_port_ff, out_port_in;
   logic [SLOT_W-1:0] out_idx_ff, out_idx_in;

   // Accept a beat every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Route a write beat to the table
   always_comb begin
      wr.en    = accept && (req_action == ACT_WRITE);
      wr.slot  = req_entry_index;
      wr.dest  = req_entry_dest;
      wr.len   = req_entry_prefix_len;
      wr.gw    = req_entry_gateway;
      wr.port  = req_entry_port;
      wr.valid = req_entry_valid;
   end

   assign s0_valid_in = accept && (req_action == ACT_LOOKUP);

   // Stage 0: capture the lookup address
   always_ff @(posedge clock) begin
      s0_addr_ff <= req_lookup_addr;
   end

   // Stage 1: table compare and first tree levels
   ipv4lpm_table u_table (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .addr  (s0_addr_ff),
      .cand  (s1_cand_in)
   );

   always_ff @(posedge clock) begin
      s1_cand_ff <= s1_cand_in;
   end

   // Stage 2: middle tree levels
   always_comb begin
      cand_type [S1_N-1:0] work;
      work = s1_cand_ff;
      for (int l = 0; l < LVL_S2; l++) begin
         for (int j = 0; j < S1_N / 2; j++) begin
            if (j < (S1_N >> (l + 1))) begin
               work[j] = cand_pick(work[2*j], work[2*j+1]);
            end
         end
      end
      for (int k = 0; k < S2_N; k++) begin
         s2_cand_in[k] = work[k];
      end
   end

   always_ff @(posedge clock) begin
      s2_cand_ff <= s2_cand_in;
   end

   // Stage 3: last tree levels, zero the payload on a miss
   always_comb begin
      s3_work = s2_cand_ff;
      for (int l = 0; l < LVL_S3; l++) begin
         for (int j = 0; j < (S2_N + 1) / 2; j++) begin
            if (j < (S2_N >> (l + 1))) begin
               s3_work[j] = cand_pick(s3_work[2*j], s3_work[2*j+1]);
            end
         end
      end
      out_hit_in  = s3_work[0].hit;
      out_gw_in   = s3_work[0].hit ? s3_work[0].gw : '0;
      out_port_in = s3_work[0].hit ? s3_work[0].port : '0;
      out_idx_in  = s3_work[0].hit ? SLOT_W'(s3_work[0].idx) : '0;
   end

   always_ff @(posedge clock) begin
      out_hit_ff  <= out_hit_in;
      out_gw_ff   <= out_gw_in;
      out_port_ff <= out_port_in;
      out_idx_ff  <= out_idx_in;
   end

   // Advance the valid bits alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   assign rsp_strobe      = out_valid_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_next_hop    = out_gw_ff;
   assign rsp_out_port    = out_port_ff;
   assign rsp_match_index = out_idx_ff;

   // Every result traces back to an accepted lookup beat
   a_strobe_from_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && (req_action == ACT_LOOKUP), 4))
      else $error("result without a matching lookup beat");

   // A miss reports an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_hit) |->
         (rsp_next_hop == '0) && (rsp_out_port == '0) && (rsp_match_index == '0))
      else $error("miss with nonzero payload");

   // A hit names a slot inside the table
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_hit) |-> (32'(rsp_match_index) < 32'(TABLE_DEPTH)))
      else $error("hit index beyond table depth");

endmodule

`default_nettype wire

/* sim/tb.sv */
// Testbench for the IPv4 longest-prefix-match route lookup unit.
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import ipv4lpm_pkg::*;

   // One lookup result as it leaves the block
   typedef struct {
      logic              hit;
      logic [ADDR_W-1:0] next_hop;
      logic [PORT_W-1:0] out_port;
      logic [SLOT_W-1:0] match_index;
   } route_result_type;

   // Shadow route table plus the queue of lookup results still to come
   class route_scoreboard;
      logic [ADDR_W-1:0] slot_dest [TABLE_DEPTH];
      logic [LEN_W-1:0]  slot_len  [TABLE_DEPTH];
      logic [ADDR_W-1:0] slot_gw   [TABLE_DEPTH];
      logic [PORT_W-1:0] slot_port [TABLE_DEPTH];
      bit                slot_on   [TABLE_DEPTH];
      route_result_type  pending_routes[$];
      int                fail_count;

      function new();
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_dest[i] = '0;
            slot_len[i]  = '0;
            slot_gw[i]   = '0;
            slot_port[i] = '0;
            slot_on[i]   = 1'b0;
         end
         fail_count = 0;
      endfunction

      // Leading-ones mask; lengths past 32 saturate
      function logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
         if (len == 0) begin
            return '0;
         end
         if (len >= MAX_LEN) begin
            return '1;
         end
         return {ADDR_W{1'b1}} << (ADDR_W - int'(len));
      endfunction

      task report(input string msg);
         $display("tb: mismatch at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      // Apply a write to the shadow table, or work out what a lookup must return
      task note_beat(input logic action, input logic [SLOT_W-1:0] idx,
                     input logic [ADDR_W-1:0] dest, input logic [LEN_W-1:0] len,
                     input logic [ADDR_W-1:0] gw, input logic [PORT_W-1:0] port,
                     input logic valid, input logic [ADDR_W-1:0] addr);
         route_result_type  res;
         logic [LEN_W-1:0]  eff;
         logic [LEN_W-1:0]  best_len;
         logic [ADDR_W-1:0] mask;
         if (action == ACT_WRITE) begin
            if (int'(idx) < TABLE_DEPTH) begin
               slot_dest[idx] = dest;
               slot_len[idx]  = len;
               slot_gw[idx]   = gw;
               slot_port[idx] = port;
               slot_on[idx]   = valid;
            end
         end else begin
            res.hit         = 1'b0;
            res.next_hop    = '0;
            res.out_port    = '0;
            res.match_index = '0;
            best_len        = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_on[i]) begin
                  eff  = (slot_len[i] > MAX_LEN) ? MAX_LEN : slot_len[i];
                  mask = prefix_mask(eff);
                  // strictly longer wins, so the lowest slot keeps a tie
                  if (((slot_dest[i] & mask) == (addr & mask)) &&
                      (!res.hit || eff > best_len)) begin
                     res.hit         = 1'b1;
                     res.next_hop    = slot_gw[i];
                     res.out_port    = slot_port[i];
                     res.match_index = SLOT_W'(i);
                     best_len        = eff;
                  end
               end
            end
            pending_routes.push_back(res);
         end
      endtask

      // Compare one result beat against the oldest pending lookup
      task check_result(input logic hit, input logic [ADDR_W-1:0] hop,
                        input logic [PORT_W-1:0] port, input logic [SLOT_W-1:0] idx);
         route_result_type want;
         if (pending_routes.size() == 0) begin
            report("result beat with no lookup pending");
         end else begin
            want = pending_routes.pop_front();
            if (hit !== want.hit) begin
               report($sformatf("hit %b, want %b", hit, want.hit));
            end
            if (hop !== want.next_hop) begin
               report($sformatf("next_hop %h, want %h", hop, want.next_hop));
            end
            if (port !== want.out_port) begin
               report($sformatf("out_port %0d, want %0d", port, want.out_port));
            end
            if (idx !== want.match_index) begin
               report($sformatf("match_index %0d, want %0d", idx, want.match_index));
            end
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_action;
   logic [SLOT_W-1:0] req_entry_index;
   logic [ADDR_W-1:0] req_entry_dest;
   logic [LEN_W-1:0]  req_entry_prefix_len;
   logic [ADDR_W-1:0] req_entry_gateway;
   logic [PORT_W-1:0] req_entry_port;
   logic              req_entry_valid;
   logic [ADDR_W-1:0] req_lookup_addr;
   logic              rsp_strobe;
   logic              rsp_hit;
   logic [ADDR_W-1:0] rsp_next_hop;
   logic [PORT_W-1:0] rsp_out_port;
   logic [SLOT_W-1:0] rsp_match_index;

   route_scoreboard   sb;
   int                sender_idle_pct;
   logic [ADDR_W-1:0] net_base [4];

   ipv4_longest_prefix_match_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_action           (req_action),
      .req_entry_index      (req_entry_index),
      .req_entry_dest       (req_entry_dest),
      .req_entry_prefix_len (req_entry_prefix_len),
      .req_entry_gateway    (req_entry_gateway),
      .req_entry_port       (req_entry_port),
      .req_entry_valid      (req_entry_valid),
      .req_lookup_addr      (req_lookup_addr),
      .rsp_strobe           (rsp_strobe),
      .rsp_hit              (rsp_hit),
      .rsp_next_hop         (rsp_next_hop),
      .rsp_out_port         (rsp_out_port),
      .rsp_match_index      (rsp_match_index)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Watch both channels; values read here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            sb.check_result(rsp_hit, rsp_next_hop, rsp_out_port, rsp_match_index);
         end
         if (start && !busy) begin
            sb.note_beat(req_action, req_entry_index, req_entry_dest, req_entry_prefix_len,
                         req_entry_gateway, req_entry_port, req_entry_valid, req_lookup_addr);
         end
      end
   end

   // Present one beat, hold it until accepted, then maybe idle a while
   task send_beat(input logic action, input logic [SLOT_W-1:0] idx,
                  input logic [ADDR_W-1:0] dest, input logic [LEN_W-1:0] len,
                  input logic [ADDR_W-1:0] gw, input logic [PORT_W-1:0] port,
                  input logic valid, input logic [ADDR_W-1:0] addr);
      start                <= 1'b1;
      req_action           <= action;
      req_entry_index      <= idx;
      req_entry_dest       <= dest;
      req_entry_prefix_len <= len;
      req_entry_gateway    <= gw;
      req_entry_port       <= port;
      req_entry_valid      <= valid;
      req_lookup_addr      <= addr;
      do @(posedge clock); while (busy);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Write one slot; the unused lookup field carries noise
   task send_write(input logic [SLOT_W-1:0] idx, input logic [ADDR_W-1:0] dest,
                   input logic [LEN_W-1:0] len, input logic [ADDR_W-1:0] gw,
                   input logic [PORT_W-1:0] port, input logic valid);
      send_beat(ACT_WRITE, idx, dest, len, gw, port, valid, $urandom);
   endtask

   // Look up one address; the unused entry fields carry noise
   task send_lookup(input logic [ADDR_W-1:0] addr);
      send_beat(ACT_LOOKUP, SLOT_W'($urandom), $urandom, LEN_W'($urandom), $urandom,
                PORT_W'($urandom), 1'($urandom), addr);
   endtask

   // Random mix: writes into a few clustered networks, lookups aimed mostly at them
   task send_random(input int count);
      int                pick;
      int                slot;
      int                cut;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] dest;
      logic [ADDR_W-1:0] mask;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 30) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
               len = '0;
            end else if (pick < 13) begin
               len = LEN_W'($urandom_range(63, 33));
            end else begin
               len = LEN_W'($urandom_range(32, 1));
            end
            if ($urandom_range(9) == 0) begin
               dest = $urandom;
            end else begin
               cut  = $urandom_range(32, 8);
               mask = sb.prefix_mask(LEN_W'(cut));
               dest = (net_base[$urandom_range(3)] & mask) | ($urandom & ~mask);
            end
            send_write(SLOT_W'($urandom_range(15)), dest, len, $urandom,
                       PORT_W'($urandom), ($urandom_range(99) < 85));
         end else begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               slot = $urandom_range(TABLE_DEPTH - 1);
               mask = sb.prefix_mask(sb.slot_len[slot]);
               send_lookup((sb.slot_dest[slot] & mask) | ($urandom & ~mask));
            end else if (pick < 85) begin
               mask = sb.prefix_mask(LEN_W'($urandom_range(24, 8)));
               send_lookup((net_base[$urandom_range(3)] & mask) | ($urandom & ~mask));
            end else begin
               send_lookup($urandom);
            end
         end
      end
   endtask

   initial begin
      int guard;
      sb                   = new();
      sender_idle_pct      = 15;
      reset                = 1'b1;
      start                = 1'b0;
      req_action           = ACT_WRITE;
      req_entry_index      = '0;
      req_entry_dest       = '0;
      req_entry_prefix_len = '0;
      req_entry_gateway    = '0;
      req_entry_port       = '0;
      req_entry_valid      = 1'b0;
      req_lookup_addr      = '0;
      for (int i = 0; i < 4; i++) begin
         net_base[i] = $urandom;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table: every lookup misses
      send_lookup(32'h0000_0000);
      send_lookup(32'hFFFF_FFFF);
      // Nested prefixes of one network
      send_write(4'd0, 32'h0A00_0000, 6'd8, 32'h0101_0101, 2'd1, 1'b1);
      send_write(4'd1, 32'h0A01_0000, 6'd16, 32'h0202_0202, 2'd2, 1'b1);
      send_write(4'd2, 32'h0A01_0200, 6'd24, 32'h0303_0303, 2'd3, 1'b1);
      send_write(4'd15, 32'h0A01_0203, 6'd32, 32'hFFFF_FFFF, 2'd0, 1'b1);
      send_lookup(32'h0A01_0203);
      send_lookup(32'h0A01_0204);
      send_lookup(32'h0A02_0000);
      send_lookup(32'h0B00_0000);
      // Default route matches everything
      send_write(4'd9, 32'hFFFF_FFFF, 6'd0, 32'hC0A8_0001, 2'd2, 1'b1);
      send_lookup(32'h0B00_0000);
      send_lookup(32'hFFFF_FFFF);
      // Equal lengths: lower slot wins until it is removed
      send_write(4'd4, 32'h0A01_0200, 6'd24, 32'h0404_0404, 2'd1, 1'b1);
      send_lookup(32'h0A01_02FF);
      send_write(4'd2, 32'h0A01_0200, 6'd24, 32'h0303_0303, 2'd3, 1'b0);
      send_lookup(32'h0A01_02FF);
      // Lengths past 32 saturate and tie with a full-length entry
      send_write(4'd7, 32'hC000_0000, 6'd63, 32'h0707_0707, 2'd3, 1'b1);
      send_write(4'd8, 32'hC000_0000, 6'd33, 32'h0808_0808, 2'd2, 1'b1);
      send_lookup(32'hC000_0000);
      send_lookup(32'hC000_0001);
      send_write(4'd7, 32'hC000_0000, 6'd63, 32'h0707_0707, 2'd3, 1'b0);
      send_lookup(32'hC000_0000);
      // Drop the default route again
      send_write(4'd9, 32'h0000_0000, 6'd0, 32'h0000_0000, 2'd0, 1'b0);
      send_lookup(32'h0B00_0000);

      // Random traffic under three idle profiles
      send_random(610);
      sender_idle_pct = 63;
      send_random(610);
      sender_idle_pct = 0;
      send_random(610);
      start <= 1'b0;

      // Drain the pipeline, then a few more cycles for strays
      guard = 0;
      while (sb.pending_routes.size() != 0 && guard < 1000) begin
         @(posedge clock);
         guard++;
      end
      repeat (10) @(posedge clock);
      if (sb.pending_routes.size() != 0) begin
         sb.report($sformatf("%0d lookup results never arrived", sb.pending_routes.size()));
      end
      if (sb.fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/ipv4lpm_pkg.sv
rtl/ipv4lpm_table.sv
rtl/ipv4_longest_prefix_match_unit.sv
sim/tb.sv
